[design/dda_pkg.sv]
// Shared types and constants for the decimal digit accumulator.
// Used by dda_digit_alu and decimal_digit_accumulator_unit; no dependencies.
package dda_pkg;

  // Command codes carried in s_tuser
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_DOUBLE = 3'd2;
  localparam logic [2:0] CMD_HALVE  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [3:0]  DIGIT_MAX = 4'd9;
  localparam logic [11:0] POINT_MAX = 12'd4095;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DOUBLE,
    OP_FIVE
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic       used;
    logic [3:0] digit;
    logic [3:0] addend;
  } alu_in_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [2:0] carry;
  } alu_out_t;

endpackage

[design/dda_digit_alu.sv]
// One decimal digit step: (digit * factor + addend) split into digit and carry.
// Depends on dda_pkg.
module dda_digit_alu (
  input  dda_pkg::alu_in_t  alu_in,
  output dda_pkg::alu_out_t alu_out
);

  logic [3:0] base;
  logic [5:0] prod;
  logic [5:0] total;
  logic [2:0] quot;

  assign base = alu_in.used ? alu_in.digit : 4'd0;

  always_comb begin
    unique case (alu_in.op)
      dda_pkg::OP_ADD:    prod = {2'b00, base};
      dda_pkg::OP_DOUBLE: prod = {1'b0, base, 1'b0};
      dda_pkg::OP_FIVE:   prod = {base, 2'b00} + {2'b00, base};
      default:            prod = {2'b00, base};
    endcase
  end

  assign total = prod + {2'b00, alu_in.addend};

  // Total stays below 50, so the quotient by ten is a short compare chain
  always_comb begin
    if (total >= 6'd40) begin
      quot = 3'd4;
    end else if (total >= 6'd30) begin
      quot = 3'd3;
    end else if (total >= 6'd20) begin
      quot = 3'd2;
    end else if (total >= 6'd10) begin
      quot = 3'd1;
    end else begin
      quot = 3'd0;
    end
  end

  assign alu_out.carry = quot;
  assign alu_out.digit = 4'(total - 6'({3'b000, quot} * 6'd10));

endmodule

[design/decimal_digit_accumulator_unit.sv]
// Top level of the decimal digit accumulator: digit memory, command sequencer
// and output register. Depends on dda_pkg and dda_digit_alu.

// The number lives in one DIGITS-entry memory, each entry a used flag and a
// BCD digit, least significant position at address 0. Every command is one
// input transaction and gives one output transaction. The sequencer reads,
// updates and writes back one position per cycle through the single memory,
// with the next position's read issued while the current one is written.
// Read visits one position, add visits the positions its carry ripples
// through, double and halve walk up from address 0 until an unused position
// with no carry. Clear sweeps all DIGITS entries, and the same sweep runs
// once after reset, during which no input is taken. A finished result waits
// in the output register while the next command is already being taken in.
module decimal_digit_accumulator_unit #(
  parameter int DIGITS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [10:0] position, [14:11] digit_in, [15] zero
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] digit_out, [15:4] fraction_count,
                                 // [16] overflow, [23:17] zero
  output logic        m_tuser    // [0] digit_valid
);

  localparam int AW = $clog2(DIGITS);

  dda_pkg::state_t state, state_next;

  logic [AW-1:0] addr;
  logic [AW-1:0] rd_addr;
  logic [2:0]    cmd;
  logic [3:0]    addend;
  logic [11:0]   point_count;
  logic          clr_reply;

  logic [3:0] res_dout;
  logic       res_dvalid;
  logic       res_ovf;

  logic [3:0]  out_dout;
  logic        out_dvalid;
  logic [11:0] out_frac;
  logic        out_ovf;

  logic [4:0] mem [DIGITS];
  logic [4:0] rdata;
  logic       mem_we;
  logic [4:0] mem_wdata;

  logic [2:0]  in_cmd;
  logic [10:0] in_pos;
  logic [3:0]  in_digit;
  logic        in_range;
  logic        accept;
  logic        is_last;
  logic        rd_used;
  logic [3:0]  rd_digit;

  dda_pkg::alu_in_t  alu_in;
  dda_pkg::alu_out_t alu_out;

  // step decode
  logic step_done;
  logic step_write;
  logic step_ovf;
  logic load_out;

  assign in_cmd   = s_tuser;
  assign in_pos   = s_tdata[10:0];
  assign in_digit = s_tdata[14:11];
  assign in_range = 32'(in_pos) < DIGITS;
  assign s_tready = (state == dda_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_last  = (addr == AW'(DIGITS - 1));
  assign rd_used  = rdata[4];
  assign rd_digit = rdata[3:0];

  // Read the start position on acceptance, else the position after the one
  // being written
  always_comb begin
    if (state == dda_pkg::ST_IDLE) begin
      if (in_cmd == dda_pkg::CMD_ADD || in_cmd == dda_pkg::CMD_READ) begin
        rd_addr = AW'(in_pos);
      end else begin
        rd_addr = '0;
      end
    end else begin
      rd_addr = AW'(addr + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    alu_in.used   = rd_used;
    alu_in.digit  = rd_digit;
    alu_in.addend = addend;
    case (cmd)
      dda_pkg::CMD_DOUBLE: alu_in.op = dda_pkg::OP_DOUBLE;
      dda_pkg::CMD_HALVE:  alu_in.op = dda_pkg::OP_FIVE;
      default:             alu_in.op = dda_pkg::OP_ADD;
    endcase
  end

  dda_digit_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  // Decide what the current position does: write it, finish, overflow
  always_comb begin
    step_done  = 1'b0;
    step_write = 1'b0;
    step_ovf   = 1'b0;
    case (cmd)
      dda_pkg::CMD_READ: begin
        step_done = 1'b1;
      end
      dda_pkg::CMD_ADD: begin
        step_write = 1'b1;
        if (alu_out.carry == 3'd0) begin
          step_done = 1'b1;
        end else if (is_last) begin
          step_done = 1'b1;
          step_ovf  = 1'b1;
        end
      end
      default: begin
        if (addend == 4'd0 && !rd_used) begin
          step_done = 1'b1;
        end else begin
          step_write = 1'b1;
          if (is_last) begin
            step_done = 1'b1;
            step_ovf  = (alu_out.carry != 3'd0);
          end
        end
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dda_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            dda_pkg::CMD_CLEAR:  state_next = dda_pkg::ST_CLEAR;
            dda_pkg::CMD_DOUBLE,
            dda_pkg::CMD_HALVE:  state_next = dda_pkg::ST_STEP;
            dda_pkg::CMD_ADD,
            dda_pkg::CMD_READ:   state_next = in_range ? dda_pkg::ST_STEP : dda_pkg::ST_DONE;
            default:             state_next = dda_pkg::ST_DONE;
          endcase
        end
      end
      dda_pkg::ST_CLEAR: begin
        if (is_last) begin
          state_next = clr_reply ? dda_pkg::ST_DONE : dda_pkg::ST_IDLE;
        end
      end
      dda_pkg::ST_STEP: begin
        if (step_done) begin
          state_next = dda_pkg::ST_DONE;
        end
      end
      dda_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = dda_pkg::ST_IDLE;
        end
      end
      default: state_next = dda_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 5'd0;
    load_out  = 1'b0;
    unique case (state)
      dda_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      dda_pkg::ST_STEP: begin
        mem_we    = step_write;
        mem_wdata = {1'b1, alu_out.digit};
      end
      dda_pkg::ST_DONE: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dda_pkg::ST_CLEAR;
      addr        <= '0;
      point_count <= '0;
      clr_reply   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        cmd        <= in_cmd;
        res_dout   <= 4'd0;
        res_dvalid <= 1'b0;
        res_ovf    <= 1'b0;
        clr_reply  <= 1'b1;
        if (in_cmd == dda_pkg::CMD_ADD || in_cmd == dda_pkg::CMD_READ) begin
          addr   <= AW'(in_pos);
          addend <= (in_digit > dda_pkg::DIGIT_MAX) ? dda_pkg::DIGIT_MAX : in_digit;
        end else begin
          addr   <= '0;
          addend <= 4'd0;
        end
      end

      if (state == dda_pkg::ST_CLEAR) begin
        point_count <= '0;
        addr        <= AW'(addr + AW'(1));
      end

      if (state == dda_pkg::ST_STEP) begin
        addr   <= AW'(addr + AW'(1));
        addend <= {1'b0, alu_out.carry};
        if (cmd == dda_pkg::CMD_READ) begin
          res_dout   <= rd_used ? rd_digit : 4'd0;
          res_dvalid <= rd_used;
        end
        if (step_done) begin
          res_ovf <= step_ovf;
        end
        // Position 0 used means a fraction digit appears
        if (cmd == dda_pkg::CMD_HALVE && addr == '0 && rd_used &&
            point_count != dda_pkg::POINT_MAX) begin
          point_count <= point_count + 12'd1;
        end
      end

      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dout   <= res_dout;
      out_dvalid <= res_dvalid;
      out_frac   <= point_count;
      out_ovf    <= res_ovf;
    end
  end

  assign m_tdata = {7'd0, out_ovf, out_frac, out_dout};
  assign m_tuser = out_dvalid;

`ifndef SYNTHESIS
  a_no_write_when_waiting: assert property (@(posedge clk) disable iff (rst)
    (state == dda_pkg::ST_IDLE || state == dda_pkg::ST_DONE) |-> !mem_we)
    else $error("memory written outside a sweep or step");

  a_addr_in_store: assert property (@(posedge clk) disable iff (rst)
    (state == dda_pkg::ST_STEP || state == dda_pkg::ST_CLEAR) |-> 32'(addr) < DIGITS)
    else $error("position beyond the store");

  a_carry_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dda_pkg::ST_STEP) |-> addend <= dda_pkg::DIGIT_MAX)
    else $error("carry or addend out of range");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == dda_pkg::ST_DONE))
    else $error("result issued without a finished command");

  a_point_changes: assert property (@(posedge clk) disable iff (rst)
    !$stable(point_count) |-> $past(state == dda_pkg::ST_STEP || state == dda_pkg::ST_CLEAR))
    else $error("fraction count changed outside halve or clear");
`endif

endmodule

[dv/tb.sv]
// Self-checking bench for decimal_digit_accumulator_unit: directed table, a halving
// run and random commands, checked against expected table values or a digit-store predictor.
// Depends on dda_pkg and the design sources.
module tb;

  localparam int NUM_DIGITS   = 2048;
  localparam int RANDOM_ITEMS = 255;
  localparam int HALVE_RUN    = 6;
  localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] CMD_LAST_UNKNOWN  = 3'd7;

  typedef struct packed {
    logic [3:0]  digit;
    logic        valid;
    logic [11:0] frac;
    logic        ovf;
  } digit_result_t;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [10:0]   pos;
    logic [3:0]    dig;
    logic          typed;
    digit_result_t want;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = dda_pkg::CMD_CLEAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  // Predictor state
  logic [3:0]  acc_digit [NUM_DIGITS];
  logic        acc_used  [NUM_DIGITS];
  logic [11:0] acc_point;

  digit_result_t pending_results[$];
  cmd_row_t      plan[$];
  bit            idle_on = 1'b1;
  int            fail_count = 0;
  int            sent_count = 0;
  int            checked_count = 0;

  decimal_digit_accumulator_unit #(
    .DIGITS(NUM_DIGITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_number();
    for (int i = 0; i < NUM_DIGITS; i++) begin
      acc_digit[i] = '0;
      acc_used[i]  = 1'b0;
    end
    acc_point = '0;
  endfunction

  // Multiply by factor, walking up until an unused position with no carry.
  function automatic logic scale_number(input int factor);
    int i;
    int carry;
    int v;
    carry = 0;
    i = 0;
    while (i < NUM_DIGITS && (carry != 0 || acc_used[i])) begin
      if (!acc_used[i]) begin
        acc_used[i]  = 1'b1;
        acc_digit[i] = '0;
      end
      v = int'(acc_digit[i]) * factor + carry;
      acc_digit[i] = 4'(v % 10);
      carry = v / 10;
      i++;
    end
    return carry != 0;
  endfunction

  function automatic logic add_at(input int pos, input int d);
    int sum;
    if (d > int'(dda_pkg::DIGIT_MAX)) d = int'(dda_pkg::DIGIT_MAX);
    while (pos < NUM_DIGITS) begin
      sum = (acc_used[pos] ? int'(acc_digit[pos]) : 0) + d;
      acc_used[pos] = 1'b1;
      if (sum > int'(dda_pkg::DIGIT_MAX)) begin
        acc_digit[pos] = 4'(sum - 10);
        pos++;
        d = 1;
      end else begin
        acc_digit[pos] = 4'(sum);
        return 1'b0;
      end
    end
    // only reached after a ripple out of the top position
    return 1'b1;
  endfunction

  function automatic digit_result_t compute_readout(input logic [2:0] cmd,
                                                    input logic [10:0] pos,
                                                    input logic [3:0] dig);
    digit_result_t r;
    r = '0;
    case (cmd)
      dda_pkg::CMD_CLEAR: clear_number();
      dda_pkg::CMD_ADD: if (pos < NUM_DIGITS) r.ovf = add_at(int'(pos), int'(dig));
      dda_pkg::CMD_DOUBLE: r.ovf = scale_number(2);
      dda_pkg::CMD_HALVE: begin
        r.ovf = scale_number(5);
        if (acc_used[0] && acc_point != dda_pkg::POINT_MAX) acc_point++;
      end
      dda_pkg::CMD_READ: begin
        if (pos < NUM_DIGITS && acc_used[pos]) begin
          r.digit = acc_digit[pos];
          r.valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.frac = acc_point;
    return r;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [10:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 11'($urandom_range(31));
    if (r < 80) return 11'($urandom_range(NUM_DIGITS - 8, NUM_DIGITS - 1));
    return 11'($urandom_range(NUM_DIGITS - 1));
  endfunction

  function automatic cmd_row_t row(input logic [2:0] cmd, input int pos, input int dig,
                                   input logic typed, input int digit, input logic valid,
                                   input int frac, input logic ovf);
    cmd_row_t r;
    r.cmd = cmd;
    r.pos = 11'(pos);
    r.dig = 4'(dig);
    r.typed = typed;
    r.want.digit = 4'(digit);
    r.want.valid = valid;
    r.want.frac = 12'(frac);
    r.want.ovf = ovf;
    return r;
  endfunction

  task automatic send_cmd(input cmd_row_t item);
    int gap;
    digit_result_t pred;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, item.dig, item.pos};
    s_tuser  <= item.cmd;
    do @(posedge clk); while (!s_tready);
    pred = compute_readout(item.cmd, item.pos, item.dig);
    pending_results.push_back(item.typed ? item.want : pred);
    sent_count++;
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : monitor
    digit_result_t got;
    digit_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.digit = m_tdata[3:0];
      got.frac  = m_tdata[15:4];
      got.ovf   = m_tdata[16];
      got.valid = m_tuser;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("digit_out", int'(want.digit), int'(got.digit));
        check_field("digit_valid", int'(want.valid), int'(got.valid));
        check_field("fraction_count", int'(want.frac), int'(got.frac));
        check_field("overflow", int'(want.ovf), int'(got.ovf));
        checked_count++;
      end
    end
  end

  initial begin : stimulus
    logic [2:0]  cmd;
    logic [10:0] pos;
    logic [3:0]  dig;
    int          sel;
    clear_number();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty store, digit clamp, ripple, top carry, unknown codes, clear
    plan.push_back(row(dda_pkg::CMD_READ,   0,    0,  1, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_READ,   2047, 0,  1, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_DOUBLE, 0,    0,  1, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_HALVE,  0,    0,  1, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_ADD,    0,    15, 1, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_READ,   0,    0,  1, 9, 1, 0, 0));
    plan.push_back(row(dda_pkg::CMD_ADD,    0,    9,  1, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_READ,   1,    0,  1, 1, 1, 0, 0));
    plan.push_back(row(dda_pkg::CMD_DOUBLE, 0,    0,  0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_HALVE,  0,    0,  0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_READ,   2,    0,  0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_ADD,    2047, 9,  1, 0, 0, 1, 0));
    plan.push_back(row(dda_pkg::CMD_ADD,    2047, 9,  1, 0, 0, 1, 1));
    plan.push_back(row(dda_pkg::CMD_READ,   2047, 0,  1, 8, 1, 1, 0));
    plan.push_back(row(dda_pkg::CMD_ADD,    1024, 0,  0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_READ,   1024, 0,  0, 0, 0, 0, 0));
    plan.push_back(row(CMD_FIRST_UNKNOWN, 2047, 15, 1, 0, 0, 1, 0));
    plan.push_back(row(CMD_LAST_UNKNOWN,  0,    0,  1, 0, 0, 1, 0));
    plan.push_back(row(dda_pkg::CMD_ADD,    1023, 9,  0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_ADD,    1023, 1,  0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_READ,   1024, 0,  0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_ADD,    'h555, 10, 0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_READ,   'h2AA, 0,  0, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_CLEAR,  0,    0,  1, 0, 0, 0, 0));
    plan.push_back(row(dda_pkg::CMD_READ,   0,    0,  1, 0, 0, 0, 0));
    foreach (plan[i]) send_cmd(plan[i]);

    // Halve a lone zero digit back to back to step the fraction count.
    wait_drain();
    idle_on = 1'b0;
    send_cmd(row(dda_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(row(dda_pkg::CMD_ADD, 0, 0, 0, 0, 0, 0, 0));
    repeat (HALVE_RUN) send_cmd(row(dda_pkg::CMD_HALVE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(row(dda_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    idle_on = 1'b1;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) idle_on = ($urandom_range(3) != 0);
      if ($urandom_range(49) == 0) wait_drain();
      sel = $urandom_range(99);
      if (sel < 3) cmd = dda_pkg::CMD_CLEAR;
      else if (sel < 40) cmd = dda_pkg::CMD_ADD;
      else if (sel < 55) cmd = dda_pkg::CMD_DOUBLE;
      else if (sel < 70) cmd = dda_pkg::CMD_HALVE;
      else if (sel < 95) cmd = dda_pkg::CMD_READ;
      else cmd = 3'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
      pos = pick_position();
      dig = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                     : 4'($urandom_range(dda_pkg::DIGIT_MAX));
      send_cmd(row(cmd, int'(pos), int'(dig), 0, 0, 0, 0, 0));
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NUM_DIGITS + 10) @(posedge clk);

    $display("Sent %0d commands (directed, halving run, random); %0d results checked.",
             sent_count, checked_count);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
